[sv/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while rst is high.
`define KFLI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kfli check failed");

// Clocked check that also holds during reset.
`define KFLI_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("kfli check failed");

`endif

[sv/kfli_pkg.sv]
package kfli_pkg;

   localparam int KEYS_DEFAULT = 64;
   localparam int TIME_W       = 24;
   localparam int VAL_W        = 32;
   localparam int FRAC_W       = 16;
   localparam int KC_W         = 7;
   localparam int KIDX_W       = 6;
   localparam int ST_W         = 2;
   localparam int NCOMP        = 3;
   localparam int COMP_W       = 2;
   localparam int DIV_CNT_W    = $clog2(FRAC_W);
   localparam int DIFF_W       = VAL_W + 1;
   localparam int PROD_W       = FRAC_W + 1 + DIFF_W;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;

   localparam logic [KC_W-1:0] KC_RESET      = 7'd1;
   localparam logic            REG_KEY_COUNT = 1'b0;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_INTERP       = 2'd0,
      ST_SINGLE       = 2'd1,
      ST_PAST_END     = 2'd2,
      ST_BEFORE_START = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_SCAN,
      S_DIV,
      S_DIFF,
      S_MULT,
      S_ACC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [NCOMP-1:0][VAL_W-1:0] val;
      logic [TIME_W-1:0]           ktime;
   } key_type;

   typedef struct packed {
      logic              wr_key;
      logic              ld_sample;
      logic              adv;
      logic              keep_prev;
      logic              emit_key;
      logic              emit_prev;
      logic              ld_status;
      status_type        res_status;
      logic              div_init;
      logic              div_step;
      logic [COMP_W-1:0] comp;
      logic              ld_diff;
      logic              ld_prod;
      logic              ld_comp;
      logic              out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic idx_last;
      logic single;
      logic t_lt_cur;
      logic t_lt_prev;
      logic out_busy;
   } dp_sts_type;

endpackage

[sv/kfli_ram.sv]
module kfli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/kfli_ctrl.sv]
module kfli_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_stall,
   input  kfli_pkg::dp_sts_type   sts,
   output kfli_pkg::dp_cmd_type   cmd
);

   kfli_pkg::state_type                  state_ff, state_in;
   logic [kfli_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [kfli_pkg::COMP_W-1:0]          comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfli_pkg::S_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      comp_in        = comp_ff;
      cmd            = '0;
      cmd.res_status = kfli_pkg::ST_INTERP;
      cmd.comp       = comp_ff;
      req_stall      = 1'b1;
      case (state_ff)
         kfli_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_cmd == kfli_pkg::CMD_SAMPLE) begin
                  cmd.ld_sample = 1'b1;
                  state_in      = kfli_pkg::S_FIRST;
               end else begin
                  cmd.wr_key = 1'b1;
               end
            end
         end
         kfli_pkg::S_FIRST: begin
            cmd.adv  = 1'b1;
            state_in = kfli_pkg::S_SCAN;
         end
         kfli_pkg::S_SCAN: begin
            cmd.adv = 1'b1;
            if (sts.idx_zero) begin
               if (sts.single) begin
                  cmd.emit_key   = 1'b1;
                  cmd.ld_status  = 1'b1;
                  cmd.res_status = kfli_pkg::ST_SINGLE;
                  state_in       = kfli_pkg::S_DONE;
               end else begin
                  cmd.keep_prev = 1'b1;
               end
            end else if (sts.t_lt_cur) begin
               if (sts.t_lt_prev) begin
                  cmd.emit_key   = 1'b1;
                  cmd.emit_prev  = 1'b1;
                  cmd.ld_status  = 1'b1;
                  cmd.res_status = kfli_pkg::ST_BEFORE_START;
                  state_in       = kfli_pkg::S_DONE;
               end else begin
                  cmd.div_init = 1'b1;
                  cnt_in       = '0;
                  state_in     = kfli_pkg::S_DIV;
               end
            end else if (sts.idx_last) begin
               cmd.emit_key   = 1'b1;
               cmd.ld_status  = 1'b1;
               cmd.res_status = kfli_pkg::ST_PAST_END;
               state_in       = kfli_pkg::S_DONE;
            end else begin
               cmd.keep_prev = 1'b1;
            end
         end
         kfli_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + kfli_pkg::DIV_CNT_W'(1);
            if (cnt_ff == kfli_pkg::DIV_CNT_W'(kfli_pkg::FRAC_W - 1)) begin
               comp_in  = '0;
               state_in = kfli_pkg::S_DIFF;
            end
         end
         kfli_pkg::S_DIFF: begin
            cmd.ld_diff = 1'b1;
            state_in    = kfli_pkg::S_MULT;
         end
         kfli_pkg::S_MULT: begin
            cmd.ld_prod = 1'b1;
            state_in    = kfli_pkg::S_ACC;
         end
         kfli_pkg::S_ACC: begin
            cmd.ld_comp = 1'b1;
            if (comp_ff == kfli_pkg::COMP_W'(kfli_pkg::NCOMP - 1)) begin
               cmd.ld_status  = 1'b1;
               cmd.res_status = kfli_pkg::ST_INTERP;
               state_in       = kfli_pkg::S_DONE;
            end else begin
               comp_in  = comp_ff + kfli_pkg::COMP_W'(1);
               state_in = kfli_pkg::S_DIFF;
            end
         end
         kfli_pkg::S_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = kfli_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kfli_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[sv/kfli_dp.sv]
module kfli_dp #(
   parameter int KEYS = kfli_pkg::KEYS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [kfli_pkg::KC_W-1:0]          key_count,
   input  logic [kfli_pkg::KIDX_W-1:0]        req_key_index,
   input  logic [kfli_pkg::TIME_W-1:0]        req_key_time,
   input  logic signed [kfli_pkg::VAL_W-1:0]  req_value_x,
   input  logic signed [kfli_pkg::VAL_W-1:0]  req_value_y,
   input  logic signed [kfli_pkg::VAL_W-1:0]  req_value_z,
   input  logic [kfli_pkg::TIME_W-1:0]        req_sample_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_x,
   output logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_y,
   output logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_z,
   output logic [kfli_pkg::ST_W-1:0]          rsp_status,
   input  kfli_pkg::dp_cmd_type               cmd,
   output kfli_pkg::dp_sts_type               sts
);

   localparam int AW = $clog2(KEYS);
   localparam int CW = (AW + 1 > kfli_pkg::KC_W) ? AW + 1 : kfli_pkg::KC_W;
   localparam int IW = (AW + 1 > kfli_pkg::KIDX_W) ? AW + 1 : kfli_pkg::KIDX_W;
   localparam int TW = kfli_pkg::TIME_W;
   localparam int VW = kfli_pkg::VAL_W;
   localparam int FW = kfli_pkg::FRAC_W;

   kfli_pkg::key_type wr_key, rd_key;
   logic [IW-1:0]     wr_idx_w;
   logic              wr_ok;
   logic [CW-1:0]     kc_w;
   logic [AW:0]       n_in;
   logic [AW:0]       nm1;

   logic [TW-1:0]     t_ff;
   logic [AW:0]       n_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     idx_ff;
   kfli_pkg::key_type prev_ff;
   logic [kfli_pkg::NCOMP-1:0][VW-1:0] end_val_ff;
   logic [TW-1:0]     rem_ff, rem_in;
   logic [TW-1:0]     den_ff;
   logic [FW-1:0]     q_ff;
   logic [TW:0]       rem2, rem_sub;
   logic              rem_ge;

   logic [VW-1:0]                      a_val, b_val;
   logic signed [kfli_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [FW:0]                 fac_s;
   logic signed [kfli_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic [kfli_pkg::NCOMP-1:0][VW-1:0] res_val_ff;
   kfli_pkg::status_type               res_st_ff;
   logic [kfli_pkg::NCOMP-1:0][VW-1:0] rsp_val_ff;
   kfli_pkg::status_type               rsp_st_ff;
   logic                               rsp_valid_ff;

   // key store
   assign wr_idx_w     = IW'(req_key_index);
   assign wr_ok        = wr_idx_w < IW'(KEYS);
   assign wr_key.ktime = req_key_time;
   assign wr_key.val   = {req_value_z, req_value_y, req_value_x};

   kfli_ram #(
      .WIDTH ($bits(kfli_pkg::key_type)),
      .DEPTH (KEYS)
   ) u_kfli_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_key & wr_ok),
      .wr_addr (wr_idx_w[AW-1:0]),
      .wr_data (wr_key),
      .rd_addr (addr_ff),
      .rd_data (rd_key)
   );

   // effective key count, 1..KEYS
   always_comb begin
      kc_w = CW'(key_count);
      if (kc_w == '0) begin
         n_in = (AW + 1)'(1);
      end else if (kc_w > CW'(KEYS)) begin
         n_in = (AW + 1)'(KEYS);
      end else begin
         n_in = (AW + 1)'(kc_w);
      end
   end

   assign nm1 = n_ff - (AW + 1)'(1);

   // scan: RAM read data always belongs to idx_ff
   always_ff @(posedge clock) begin
      idx_ff <= addr_ff;
      if (cmd.ld_sample) begin
         t_ff    <= req_sample_time;
         n_ff    <= n_in;
         addr_ff <= '0;
      end else if (cmd.adv) begin
         addr_ff <= addr_ff + AW'(1);
      end
      if (cmd.keep_prev) begin
         prev_ff <= rd_key;
      end
   end

   // restoring divider, one quotient bit per step
   assign rem2    = {rem_ff, 1'b0};
   assign rem_ge  = rem2 >= {1'b0, den_ff};
   assign rem_sub = rem2 - {1'b0, den_ff};
   assign rem_in  = rem_ge ? rem_sub[TW-1:0] : rem2[TW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff     <= t_ff - prev_ff.ktime;
         den_ff     <= rd_key.ktime - prev_ff.ktime;
         end_val_ff <= rd_key.val;
         q_ff       <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[FW-2:0], rem_ge};
      end
   end

   // lerp, one component at a time on a shared multiplier
   assign a_val   = prev_ff.val[cmd.comp];
   assign b_val   = end_val_ff[cmd.comp];
   assign diff_in = $signed({b_val[VW-1], b_val}) - $signed({a_val[VW-1], a_val});
   assign fac_s   = $signed({1'b0, q_ff});
   assign prod_in = fac_s * diff_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.ld_prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.emit_key) begin
         res_val_ff <= cmd.emit_prev ? prev_ff.val : rd_key.val;
      end else if (cmd.ld_comp) begin
         res_val_ff[cmd.comp] <= a_val + prod_ff[FW+VW-1:FW];
      end
      if (cmd.ld_status) begin
         res_st_ff <= cmd.res_status;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_val_ff <= res_val_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_val_ff[0];
   assign rsp_out_y  = rsp_val_ff[1];
   assign rsp_out_z  = rsp_val_ff[2];
   assign rsp_status = rsp_st_ff;

   assign sts.idx_zero  = idx_ff == '0;
   assign sts.idx_last  = idx_ff == nm1[AW-1:0];
   assign sts.single    = n_ff == (AW + 1)'(1);
   assign sts.t_lt_cur  = t_ff < rd_key.ktime;
   assign sts.t_lt_prev = t_ff < prev_ff.ktime;
   assign sts.out_busy  = rsp_valid_ff & rsp_stall;

endmodule

[sv/keyframe_linear_interpolator_unit.sv]
// Keyframe linear interpolator.
// req channel (valid/stall): a beat with req_cmd = write stores one key
// (time, x, y, z) at req_key_index and gives no result; a beat with
// req_cmd = sample gives exactly one rsp beat for req_sample_time.
// rsp channel (valid/stall): interpolated x, y, z and a status code.
// csr port: key_count at byte address 0, number of keys in use.
// Write beats can follow back to back.
// A sample walks the key store one key per cycle from the first key,
// then runs a restoring divider for the factor and three lerp passes
// (diff, multiply, accumulate) on one shared multiplier.
// The next beat is taken the cycle after the result enters the output
// register; until then a sample holds off all further beats.
// When the receiver stalls, the result holds in that register; a later
// sample finishes its work and waits for the register to free up.
// Reset clears control and sets key_count to 1; key contents are not
// cleared and must be written before use.
module keyframe_linear_interpolator_unit #(
   parameter int KEYS = kfli_pkg::KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [kfli_pkg::KIDX_W-1:0]         req_key_index,
   input  logic [kfli_pkg::TIME_W-1:0]         req_key_time,
   input  logic signed [kfli_pkg::VAL_W-1:0]   req_value_x,
   input  logic signed [kfli_pkg::VAL_W-1:0]   req_value_y,
   input  logic signed [kfli_pkg::VAL_W-1:0]   req_value_z,
   input  logic [kfli_pkg::TIME_W-1:0]         req_sample_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kfli_pkg::VAL_W-1:0]   rsp_out_x,
   output logic signed [kfli_pkg::VAL_W-1:0]   rsp_out_y,
   output logic signed [kfli_pkg::VAL_W-1:0]   rsp_out_z,
   output logic [kfli_pkg::ST_W-1:0]           rsp_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [kfli_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [kfli_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [kfli_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   logic [kfli_pkg::KC_W-1:0] key_count_ff, key_count_in;
   logic                      csr_wr;
   logic                      csr_sel_kc;
   kfli_pkg::dp_cmd_type      cmd;
   kfli_pkg::dp_sts_type      sts;

   assign csr_pready = 1'b1;
   assign csr_sel_kc = csr_paddr[kfli_pkg::CSR_AW-1:2] == kfli_pkg::REG_KEY_COUNT;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      key_count_in = key_count_ff;
      if (csr_wr && csr_sel_kc) begin
         key_count_in = csr_pwdata[kfli_pkg::KC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kfli_pkg::KC_RESET;
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   assign csr_prdata = csr_sel_kc ? kfli_pkg::CSR_DW'(key_count_ff) : '0;

   kfli_ctrl u_kfli_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kfli_dp #(
      .KEYS (KEYS)
   ) u_kfli_dp (
      .clock           (clock),
      .reset           (reset),
      .key_count       (key_count_ff),
      .req_key_index   (req_key_index),
      .req_key_time    (req_key_time),
      .req_value_x     (req_value_x),
      .req_value_y     (req_value_y),
      .req_value_z     (req_value_z),
      .req_sample_time (req_sample_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

[sv/kfli_checker.sv]
`include "assert_macros.svh"

module kfli_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_cmd,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [kfli_pkg::VAL_W-1:0] rsp_out_x,
   input logic [kfli_pkg::ST_W-1:0]         rsp_status
);

   // no result beat right after reset
   `KFLI_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid)

   // a sample beat holds off the next request beat
   `KFLI_ASSERT(a_sample_stalls, clock, reset, (req_valid && !req_stall && req_cmd) |=> req_stall)

   // a result only appears at the end of a sample's work
   `KFLI_ASSERT(a_rsp_after_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall))

   // stalled result beat holds
   `KFLI_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_x) && $stable(rsp_status)))

endmodule

bind keyframe_linear_interpolator_unit kfli_checker u_kfli_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_cmd    (req_cmd),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_out_x  (rsp_out_x),
   .rsp_status (rsp_status)
);

[test/keyframe_linear_interpolator_unit_tb.sv]
module keyframe_linear_interpolator_unit_tb;

   localparam int NKEYS        = kfli_pkg::KEYS_DEFAULT;
   localparam int TIME_MAX     = (1 << kfli_pkg::TIME_W) - 1;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_BEATS  = 50;
   localparam logic [kfli_pkg::CSR_AW-1:0] KEY_COUNT_ADDR =
      kfli_pkg::CSR_AW'(4 * kfli_pkg::REG_KEY_COUNT);

   typedef struct {
      logic signed [kfli_pkg::VAL_W-1:0] x;
      logic signed [kfli_pkg::VAL_W-1:0] y;
      logic signed [kfli_pkg::VAL_W-1:0] z;
      kfli_pkg::status_type              st;
   } lerp_beat_type;

   class keyframe_scoreboard_type;
      logic [kfli_pkg::TIME_W-1:0]       ktime[NKEYS];
      logic signed [kfli_pkg::VAL_W-1:0] kx[NKEYS];
      logic signed [kfli_pkg::VAL_W-1:0] ky[NKEYS];
      logic signed [kfli_pkg::VAL_W-1:0] kz[NKEYS];
      logic [kfli_pkg::KC_W-1:0]         key_count;
      lerp_beat_type                     expected_q[$];
      int                                mismatches;

      function new();
         key_count  = kfli_pkg::KC_RESET;
         mismatches = 0;
      endfunction

      function void queue_expected(lerp_beat_type b);
         expected_q = {expected_q, b};
      endfunction

      function int unsigned active_keys();
         int unsigned n;
         n = key_count;
         if (n == 0) n = 1;
         if (n > NKEYS) n = NKEYS;
         return n;
      endfunction

      function lerp_beat_type key_beat(int unsigned k, kfli_pkg::status_type st);
         lerp_beat_type b;
         b.x  = kx[k];
         b.y  = ky[k];
         b.z  = kz[k];
         b.st = st;
         return b;
      endfunction

      // start + floor(f * (e - s) / 2^16)
      function logic signed [kfli_pkg::VAL_W-1:0] blend(
         logic signed [kfli_pkg::VAL_W-1:0] s, e, longint unsigned f);
         longint diff, prod, sum;
         diff = longint'(e) - longint'(s);
         prod = longint'(f) * diff;
         sum  = longint'(s) + (prod >>> kfli_pkg::FRAC_W);
         return sum[kfli_pkg::VAL_W-1:0];
      endfunction

      function void note_beat(kfli_pkg::cmd_type cmd, logic [kfli_pkg::KIDX_W-1:0] idx,
                              logic [kfli_pkg::TIME_W-1:0] kt,
                              logic signed [kfli_pkg::VAL_W-1:0] vx, vy, vz,
                              logic [kfli_pkg::TIME_W-1:0] t);
         int unsigned     n, i;
         longint unsigned num, dt, f;
         lerp_beat_type   b;
         if (cmd == kfli_pkg::CMD_WRITE) begin
            ktime[idx] = kt;
            kx[idx]    = vx;
            ky[idx]    = vy;
            kz[idx]    = vz;
            return;
         end
         n = active_keys();
         if (n == 1) begin
            queue_expected(key_beat(0, kfli_pkg::ST_SINGLE));
            return;
         end
         for (i = 0; i + 1 < n; i++) begin
            if (t < ktime[i+1]) break;
         end
         if (i + 1 >= n) begin
            queue_expected(key_beat(n - 1, kfli_pkg::ST_PAST_END));
         end else if (t < ktime[i]) begin
            queue_expected(key_beat(i, kfli_pkg::ST_BEFORE_START));
         end else begin
            dt  = ktime[i+1] - ktime[i];
            num = longint'(t - ktime[i]) << kfli_pkg::FRAC_W;
            f   = num / dt;
            if (f > 65535) f = 65535;
            b.x  = blend(kx[i], kx[i+1], f);
            b.y  = blend(ky[i], ky[i+1], f);
            b.z  = blend(kz[i], kz[i+1], f);
            b.st = kfli_pkg::ST_INTERP;
            queue_expected(b);
         end
      endfunction

      function void log_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic signed [kfli_pkg::VAL_W-1:0] x, y, z,
                                 logic [kfli_pkg::ST_W-1:0] st);
         lerp_beat_type e;
         if (expected_q.size() == 0) begin
            log_mismatch($sformatf("unexpected rsp beat x=%h y=%h z=%h status=%0d",
                                   x, y, z, st));
            return;
         end
         e = expected_q.pop_front();
         if (e.x !== x || e.y !== y || e.z !== z || e.st !== st)
            log_mismatch($sformatf({"rsp mismatch: exp x=%h y=%h z=%h status=%0d,",
                                    " got x=%h y=%h z=%h status=%0d"},
                                   e.x, e.y, e.z, e.st, x, y, z, st));
      endfunction

      function void check_key_count(logic [kfli_pkg::CSR_DW-1:0] rd);
         if (rd !== kfli_pkg::CSR_DW'(key_count))
            log_mismatch($sformatf("key_count readback: exp %0d, got %0d", key_count, rd));
      endfunction
   endclass

   logic                               clock;
   logic                               reset           = 1'b1;
   logic                               req_valid       = 1'b0;
   logic                               req_stall;
   logic                               req_cmd         = 1'b0;
   logic [kfli_pkg::KIDX_W-1:0]        req_key_index   = '0;
   logic [kfli_pkg::TIME_W-1:0]        req_key_time    = '0;
   logic signed [kfli_pkg::VAL_W-1:0]  req_value_x     = '0;
   logic signed [kfli_pkg::VAL_W-1:0]  req_value_y     = '0;
   logic signed [kfli_pkg::VAL_W-1:0]  req_value_z     = '0;
   logic [kfli_pkg::TIME_W-1:0]        req_sample_time = '0;
   logic                               rsp_valid;
   logic                               rsp_stall       = 1'b0;
   logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_x;
   logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_y;
   logic signed [kfli_pkg::VAL_W-1:0]  rsp_out_z;
   logic [kfli_pkg::ST_W-1:0]          rsp_status;
   logic                               csr_psel        = 1'b0;
   logic                               csr_penable     = 1'b0;
   logic                               csr_pwrite      = 1'b0;
   logic [kfli_pkg::CSR_AW-1:0]        csr_paddr       = '0;
   logic [kfli_pkg::CSR_DW-1:0]        csr_pwdata      = '0;
   logic [kfli_pkg::CSR_DW-1:0]        csr_prdata;
   logic                               csr_pready;

   keyframe_scoreboard_type sb;
   logic [NKEYS-1:0]        written = '0;
   int                      snd_idle_pct = 11;
   int                      rcv_idle_pct = 81;

   keyframe_linear_interpolator_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** keyframe_linear_interpolator_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_x, rsp_out_y, rsp_out_z, rsp_status);
         rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
   end

   task automatic send_beat(kfli_pkg::cmd_type cmd, logic [kfli_pkg::KIDX_W-1:0] idx,
                            logic [kfli_pkg::TIME_W-1:0] kt,
                            logic [kfli_pkg::VAL_W-1:0] vx, vy, vz,
                            logic [kfli_pkg::TIME_W-1:0] t);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_key_index   <= idx;
      req_key_time    <= kt;
      req_value_x     <= vx;
      req_value_y     <= vy;
      req_value_z     <= vz;
      req_sample_time <= t;
      do @(posedge clock); while (req_stall);
      sb.note_beat(cmd, idx, kt, vx, vy, vz, t);
   endtask

   task automatic write_key(logic [kfli_pkg::KIDX_W-1:0] idx, logic [kfli_pkg::TIME_W-1:0] kt,
                            logic [kfli_pkg::VAL_W-1:0] vx, vy, vz);
      send_beat(kfli_pkg::CMD_WRITE, idx, kt, vx, vy, vz, kfli_pkg::TIME_W'($urandom));
      written[idx] = 1'b1;
   endtask

   task automatic sample(logic [kfli_pkg::TIME_W-1:0] t);
      send_beat(kfli_pkg::CMD_SAMPLE, kfli_pkg::KIDX_W'($urandom),
                kfli_pkg::TIME_W'($urandom), $urandom, $urandom, $urandom, t);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [kfli_pkg::CSR_DW-1:0] wdata,
                             output logic [kfli_pkg::CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= KEY_COUNT_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // only while idle: drain results, then let any trailing write beats settle
   task automatic set_key_count(int unsigned v);
      logic [kfli_pkg::CSR_DW-1:0] rd;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(1'b1, kfli_pkg::CSR_DW'(v), rd);
      sb.key_count = kfli_pkg::KC_W'(v);
      csr_access(1'b0, '0, rd);
      sb.check_key_count(rd);
   endtask

   task automatic load_ascending_keys(int unsigned m);
      int unsigned t, stride;
      t      = $urandom_range(0, 255);
      stride = (m > 1) ? (TIME_MAX - t) / (m - 1) : 0;
      for (int unsigned k = 0; k < m; k++) begin
         write_key(kfli_pkg::KIDX_W'(k), kfli_pkg::TIME_W'(t), $urandom, $urandom, $urandom);
         if ($urandom_range(0, 19) != 0) t += $urandom_range(1, stride);
      end
   endtask

   function automatic logic [kfli_pkg::TIME_W-1:0] pick_sample_time(int unsigned n);
      int unsigned i, lo, hi, r;
      r = $urandom_range(0, 9);
      if (r == 0 || n < 2) return kfli_pkg::TIME_W'($urandom);
      if (r == 1)
         return (sb.ktime[0] == 0) ? '0 :
                kfli_pkg::TIME_W'($urandom_range(0, sb.ktime[0] - 1));
      if (r == 2) return kfli_pkg::TIME_W'($urandom_range(sb.ktime[n-1], TIME_MAX));
      i  = $urandom_range(0, n - 2);
      lo = sb.ktime[i];
      hi = sb.ktime[i+1];
      return (hi > lo) ? kfli_pkg::TIME_W'($urandom_range(lo, hi - 1)) :
                         kfli_pkg::TIME_W'(lo);
   endfunction

   task automatic run_phase(int unsigned count_val, int snd_pct, int rcv_pct, bit pause_mid);
      int unsigned n, k;
      bit          ready;
      set_key_count(count_val);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      n     = sb.active_keys();
      ready = 1'b1;
      for (k = 0; k < n; k++) begin
         if (!written[k]) ready = 1'b0;
      end
      if (n <= 16 || !ready) load_ascending_keys(n);
      for (int j = 0; j < PHASE_BEATS; j++) begin
         if (pause_mid && j == PHASE_BEATS / 2) wait_drained();
         if ($urandom_range(0, 99) < 20)
            write_key(kfli_pkg::KIDX_W'($urandom), kfli_pkg::TIME_W'($urandom),
                      $urandom, $urandom, $urandom);
         else
            sample(pick_sample_time(n));
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single key in use after reset
      write_key(6'd0, 24'h000100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      sample(24'h000000);
      sample(24'hFFFFFF);
      write_key(6'd1, 24'h000200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      write_key(6'd2, 24'h000300, 32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF);
      write_key(6'd3, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      write_key(6'd63, 24'h000000, $urandom, $urandom, $urandom);

      set_key_count(4);
      sample(24'h000000);
      sample(24'h0000FF);
      sample(24'h000100);
      sample(24'h000180);
      sample(24'h0001FF);
      sample(24'h000200);
      sample(24'h0002AA);
      sample(24'h000300);
      sample(24'h800000);
      sample(24'hFFFFFE);
      sample(24'hFFFFFF);

      run_phase(2, 11, 81, 1'b1);
      run_phase(0, 11, 81, 1'b0);
      run_phase(64, 81, 11, 1'b0);
      run_phase(127, 81, 11, 1'b0);
      run_phase($urandom_range(3, 16), 0, 0, 1'b0);
      run_phase(1, 0, 0, 1'b0);
      run_phase($urandom_range(17, 63), 0, 0, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("** keyframe_linear_interpolator_unit: PASSED **");
      else
         $display("** keyframe_linear_interpolator_unit: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/kfli_pkg.sv
sv/kfli_ram.sv
sv/kfli_ctrl.sv
sv/kfli_dp.sv
sv/keyframe_linear_interpolator_unit.sv
sv/kfli_checker.sv
test/keyframe_linear_interpolator_unit_tb.sv
